// File: sv/hsec_pkg.sv
package hsec_pkg;

	localparam int WORD_W   = 63;
	localparam int SYN_W    = 6;
	localparam int STATUS_W = 2;

	// Request codes
	localparam logic REQ_ENCODE  = 1'b0;
	localparam logic REQ_CORRECT = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_CLEAN     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FIXED     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BEYOND    = 2'd2;

	// One classified request between front and back
	typedef struct packed {
		logic              req_type;
		logic [WORD_W-1:0] word;
		logic [SYN_W-1:0]  code_len;
	} entry_t;

	// Place data bits, in order, into the positions that are not powers of two.
	// Position i is bit i-1; the mapping is fixed wiring.
	function automatic logic [WORD_W-1:0] scatter_data(input logic [WORD_W-1:0] data);
		logic [WORD_W-1:0] res;
		int d;
		res = '0;
		d = 0;
		for (int i = 1; i <= WORD_W; i++) begin
			if ((i & (i - 1)) != 0) begin
				res[i-1] = data[d];
				d++;
			end
		end
		return res;
	endfunction

endpackage

// File: sv/hsec_front.sv
module hsec_front #(
	parameter int MAX_PARITY_BITS = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [5:0]                  cfg_wdata,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        req_type,
	input  logic [hsec_pkg::WORD_W-1:0] data_word,
	output logic                        push,
	output hsec_pkg::entry_t            entry
);

	localparam int MAX_K = (1 << MAX_PARITY_BITS) - MAX_PARITY_BITS - 1;

	logic [5:0]                  data_bits_q;
	logic [5:0]                  k_eff;
	logic [2:0]                  par_cnt;
	logic [5:0]                  code_len;
	logic [hsec_pkg::WORD_W-1:0] k_mask;
	logic [hsec_pkg::WORD_W-1:0] n_mask;

	// Hold the data length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= 6'd4;
		end else if (cfg_we) begin
			data_bits_q <= cfg_wdata;
		end
	end

	// Clamp data length, derive parity count and code length
	always_comb begin
		if (data_bits_q == 6'd0) begin
			k_eff = 6'd1;
		end else if (data_bits_q > 6'(MAX_K)) begin
			k_eff = 6'(MAX_K);
		end else begin
			k_eff = data_bits_q;
		end
		par_cnt = 3'd1;
		for (int s = 1; s < MAX_PARITY_BITS; s++) begin
			if ((7'd1 << par_cnt) < (7'(k_eff) + 7'(par_cnt) + 7'd1)) begin
				par_cnt = par_cnt + 3'd1;
			end
		end
		code_len = k_eff + 6'(par_cnt);
	end

	// Build length masks
	always_comb begin
		for (int b = 0; b < hsec_pkg::WORD_W; b++) begin
			k_mask[b] = 6'(b) < k_eff;
			n_mask[b] = 6'(b) < code_len;
		end
	end

	// Classify: scatter data for encode, trim codeword for correct
	always_comb begin
		entry.req_type = req_type;
		entry.code_len = code_len;
		if (req_type == hsec_pkg::REQ_ENCODE) begin
			entry.word = hsec_pkg::scatter_data(data_word & k_mask);
		end else begin
			entry.word = data_word & n_mask;
		end
	end

	assign push = start && !busy;

endmodule

// File: sv/hsec_queue.sv
module hsec_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hsec_pkg::entry_t push_entry,
	input  logic             pop,
	output hsec_pkg::entry_t head,
	output logic             not_empty,
	output logic             full
);

	hsec_pkg::entry_t slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// Hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head      = slot_q[rd_ptr_q];
	assign not_empty = count_q != 2'd0;
	assign full      = count_q == 2'd2;

endmodule

// File: sv/hsec_back.sv
module hsec_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid,
	input  hsec_pkg::entry_t              entry,
	output logic                          done,
	output logic [hsec_pkg::WORD_W-1:0]   code_out,
	output logic [hsec_pkg::SYN_W-1:0]    syndrome,
	output logic [hsec_pkg::STATUS_W-1:0] status
);

	logic [hsec_pkg::SYN_W-1:0]    syn;
	logic [hsec_pkg::WORD_W-1:0]   parity_bits;
	logic [hsec_pkg::WORD_W-1:0]   flip;
	logic [hsec_pkg::WORD_W-1:0]   code_d;
	logic [hsec_pkg::SYN_W-1:0]    syn_d;
	logic [hsec_pkg::STATUS_W-1:0] status_d;
	logic                          done_q;
	logic [hsec_pkg::WORD_W-1:0]   code_q;
	logic [hsec_pkg::SYN_W-1:0]    syn_q;
	logic [hsec_pkg::STATUS_W-1:0] status_q;

	// XOR each syndrome bit over positions that have that bit set
	always_comb begin
		for (int j = 0; j < hsec_pkg::SYN_W; j++) begin
			syn[j] = 1'b0;
			for (int i = 1; i <= hsec_pkg::WORD_W; i++) begin
				if (((i >> j) & 1) != 0) begin
					syn[j] = syn[j] ^ entry.word[i-1];
				end
			end
		end
	end

	// Parity placement and single-bit flip vectors
	always_comb begin
		parity_bits = '0;
		for (int j = 0; j < hsec_pkg::SYN_W; j++) begin
			parity_bits[(1 << j) - 1] = syn[j];
		end
		for (int b = 0; b < hsec_pkg::WORD_W; b++) begin
			flip[b] = syn == 6'(b + 1);
		end
	end

	// Finish encode or correct
	always_comb begin
		if (entry.req_type == hsec_pkg::REQ_ENCODE) begin
			code_d   = entry.word | parity_bits;
			syn_d    = '0;
			status_d = hsec_pkg::ST_CLEAN;
		end else begin
			syn_d = syn;
			if (syn == '0) begin
				code_d   = entry.word;
				status_d = hsec_pkg::ST_CLEAN;
			end else if (syn > entry.code_len) begin
				code_d   = entry.word;
				status_d = hsec_pkg::ST_BEYOND;
			end else begin
				code_d   = entry.word ^ flip;
				status_d = hsec_pkg::ST_FIXED;
			end
		end
	end

	// Strobe the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid;
		end
	end

	// Hold result payload
	always_ff @(posedge clk) begin
		if (valid) begin
			code_q   <= code_d;
			syn_q    <= syn_d;
			status_q <= status_d;
		end
	end

	assign done     = done_q;
	assign code_out = code_q;
	assign syndrome = syn_q;
	assign status   = status_q;

endmodule

// File: sv/hamming_sec_encode_correct_top.sv
// Hamming single-error-correcting coder. A request is taken at a clock edge
// with start high and busy low; it is queued, then registered, and shows on
// code_out, syndrome and status for exactly one cycle with done high. The
// receiver cannot stall: one request per cycle goes in and one result per
// cycle comes out, since the back end drains the two-entry queue every cycle,
// so busy stays low in normal use. The front end trims or scatters the word
// by the current data length; the back end runs the syndrome XOR trees and
// sets parity or flips the named bit. Write data_bits only while idle.
module hamming_sec_encode_correct_top #(
	parameter int MAX_PARITY_BITS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [5:0]                    cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [hsec_pkg::WORD_W-1:0]   data_word,
	output logic                          done,
	output logic [hsec_pkg::WORD_W-1:0]   code_out,
	output logic [hsec_pkg::SYN_W-1:0]    syndrome,
	output logic [hsec_pkg::STATUS_W-1:0] status
);

	logic             push;
	hsec_pkg::entry_t push_entry;
	hsec_pkg::entry_t head;
	logic             not_empty;
	logic             full;

	hsec_front #(
		.MAX_PARITY_BITS(MAX_PARITY_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.busy      (full),
		.req_type  (req_type),
		.data_word (data_word),
		.push      (push),
		.entry     (push_entry)
	);

	hsec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (not_empty),
		.head       (head),
		.not_empty  (not_empty),
		.full       (full)
	);

	hsec_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (not_empty),
		.entry    (head),
		.done     (done),
		.code_out (code_out),
		.syndrome (syndrome),
		.status   (status)
	);

	assign busy = full;

endmodule
